>>> design/ptpe_pkg.sv
// Shared constants and types for the page turn pace estimator.
// No dependencies; imported by ptpe_cdiv and page_turn_pace_estimator_core.
package ptpe_pkg;

  // Field widths
  localparam int unsigned PAGE_W     = 16;
  localparam int unsigned TARGET_W   = 17;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned PACE_W     = 26;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned MINUTES_W  = 18;
  localparam int unsigned INTERVAL_W = 18;
  localparam int unsigned FRAC_W     = 8;

  // Stream payload widths, padded to whole bytes
  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 80;

  // Interval window and estimate rules
  localparam int unsigned SAMPLE_MIN_MS = 600;
  localparam int unsigned SAMPLE_MAX_MS = 240000;
  localparam int unsigned MIN_SAMPLES   = 3;

  // Average update: (4*avg + 256*interval + 2) / 5
  localparam int unsigned EMA_NUM_W  = 29;
  localparam int unsigned EMA_REM_W  = 3;
  localparam int unsigned EMA_DIV    = 5;
  localparam int unsigned EMA_ROUND  = 2;

  // Minutes: (rem * avg + 59999*256) / (60000*256)
  localparam int unsigned PROD_W     = 42;
  localparam int unsigned MIN_QUOT_W = 19;
  localparam int unsigned MIN_REM_W  = 24;
  localparam int unsigned MIN_DIV    = 15360000;
  localparam int unsigned MIN_ROUND  = 15359744;
  localparam int unsigned MUL_CNT_W  = 4;

  typedef enum logic {
    CMD_MOVE  = 1'b0,
    CMD_RESET = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EMA,
    ST_EVAL,
    ST_MUL,
    ST_ADJ,
    ST_DIV,
    ST_DONE
  } state_e;

endpackage

>>> design/ptpe_cdiv.sv
// Bit-serial restoring divider by a constant: one quotient bit per cycle.
// Depends on ptpe_pkg for default widths.
module ptpe_cdiv import ptpe_pkg::*; #(
  parameter int unsigned NUM_W   = EMA_NUM_W,
  parameter int unsigned REM_W   = EMA_REM_W,
  parameter int unsigned DIVISOR = EMA_DIV
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [REM_W-1:0] rem_i,   // upper dividend bits, must be below DIVISOR
  input  logic [NUM_W-1:0] num_i,   // lower dividend bits, shifted in MSB first
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int unsigned CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;
  localparam logic [REM_W:0] DIV_EXT = (REM_W + 1)'(DIVISOR);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NUM_W - 1);

  logic [REM_W-1:0] rem_q, rem_d;
  logic [NUM_W-1:0] num_q, num_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [REM_W:0]   trial;
  logic [REM_W:0]   diff;
  logic             ge;

  // Trial subtract of the divisor from the shifted remainder
  assign trial = {rem_q, num_q[NUM_W-1]};
  assign diff  = trial - DIV_EXT;
  assign ge    = (trial >= DIV_EXT);

  // Advance one quotient bit per cycle while busy
  always_comb begin
    rem_d  = rem_q;
    num_d  = num_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = rem_i;
      num_d  = num_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
      num_d = {num_q[NUM_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST_STEP) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Hold the datapath; no reset needed
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

>>> design/page_turn_pace_estimator_core.sv
// Page turn pace estimator core; depends on ptpe_pkg and ptpe_cdiv.
// Flow: input transfer in idle, an optional divide-by-five average update (29 steps),
// evaluate, the minutes multiply (16 steps), adjust and divide (19 steps), then result load.
// Throughput: one item in work at a time; the next input transfer can come in the cycle after
// the result is loaded, and a result-side stall holds the result load back.
// Reset (rst_ni low, asynchronous) clears page count, position, time, average, count.
module page_turn_pace_estimator_core import ptpe_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration: page_total
  input  logic                  cfg_we_i,
  input  logic [PAGE_W-1:0]     cfg_wdata_i,
  // Input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // target_page[16:0], now_ms[48:17], zero pad
  input  logic                  s_axis_tuser,  // command
  // Result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // current_page[15:0], pace_q8[41:16],
                                               // sample_total[57:42], minutes_left[75:58]
  output logic                  m_axis_tuser   // estimate_valid
);

  localparam logic [TIME_W-1:0]  SMIN   = TIME_W'(SAMPLE_MIN_MS);
  localparam logic [TIME_W-1:0]  SMAX   = TIME_W'(SAMPLE_MAX_MS);
  localparam logic [COUNT_W-1:0] NMIN   = COUNT_W'(MIN_SAMPLES);
  localparam logic [COUNT_W-1:0] NSAT   = '1;
  localparam logic [PROD_W-1:0]  MROUND = PROD_W'(MIN_ROUND);
  localparam logic [EMA_NUM_W-1:0] EROUND = EMA_NUM_W'(EMA_ROUND);
  localparam logic [MUL_CNT_W-1:0] MUL_LAST = '1;

  state_e state_q, state_d;

  logic [PAGE_W-1:0]    page_total_q;
  logic [PAGE_W-1:0]    page_pos_q;
  logic [TIME_W-1:0]    last_q;
  logic [PACE_W-1:0]    pace_q;
  logic [COUNT_W-1:0]   count_q;
  logic                 valid_q;
  logic [MINUTES_W-1:0] min_q;
  logic [PROD_W-1:0]    prod_q;
  logic [MUL_CNT_W-1:0] mcnt_q;
  logic                 m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_q;
  logic                 m_user_q;

  logic                 accept;
  logic                 cmd_reset;
  logic [TARGET_W-1:0]  target;
  logic [TIME_W-1:0]    now;
  logic [PAGE_W-1:0]    last_page;
  logic [PAGE_W-1:0]    next_page;
  logic [PAGE_W-1:0]    page_delta;
  logic                 one_step;
  logic                 jump;
  logic [TIME_W-1:0]    elapsed;
  logic                 take;
  logic                 first;
  logic [COUNT_W-1:0]   count_inc;
  logic [EMA_NUM_W-1:0] ema_num;
  logic                 est_valid;
  logic [PAGE_W-1:0]    pos_cl;
  logic [PAGE_W-1:0]    rem_pages;
  logic [PACE_W:0]      mul_sum;
  logic [PROD_W-1:0]    min_num;
  logic                 out_load;
  logic                 ema_start;
  logic                 min_start;
  logic                 ema_done;
  logic                 min_done;
  logic [EMA_NUM_W-1:0] ema_quot;
  logic [MIN_QUOT_W-1:0] min_quot;

  // Decode the input transfer
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign cmd_reset = (s_axis_tuser == CMD_RESET);
  assign target    = s_axis_tdata[TARGET_W-1:0];
  assign now       = s_axis_tdata[TARGET_W+TIME_W-1:TARGET_W];
  assign last_page = page_total_q - 1'b1;

  // Clamp the requested page and measure the move
  always_comb begin
    if (page_total_q == '0 || target[TARGET_W-1]) begin
      next_page = '0;
    end else if (target[PAGE_W-1:0] >= page_total_q) begin
      next_page = last_page;
    end else begin
      next_page = target[PAGE_W-1:0];
    end
    page_delta = (next_page >= page_pos_q) ? next_page - page_pos_q
                                           : page_pos_q - next_page;
  end

  assign one_step  = (page_delta == PAGE_W'(1));
  assign jump      = (page_delta > PAGE_W'(1));
  assign elapsed   = now - last_q;
  assign take      = one_step && (last_q != '0) && (now > last_q) &&
                     (elapsed >= SMIN) && (elapsed <= SMAX);
  assign first     = (count_q == '0);
  assign count_inc = (count_q == NSAT) ? count_q : count_q + 1'b1;
  assign ema_num   = {1'b0, pace_q, 2'b00} +
                     {3'b000, elapsed[INTERVAL_W-1:0], {FRAC_W{1'b0}}} + EROUND;

  // Estimate qualifier and remaining pages
  assign est_valid = (page_total_q != '0) && (count_q >= NMIN) && (pace_q != '0);
  assign pos_cl    = (page_pos_q >= page_total_q) ? last_page : page_pos_q;
  assign rem_pages = last_page - pos_cl;

  // Shift-add multiply step and rounding offset for the minutes divide
  assign mul_sum = {1'b0, prod_q[PROD_W-1:PAGE_W]} + (prod_q[0] ? {1'b0, pace_q} : '0);
  assign min_num = prod_q + MROUND;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (!cmd_reset && take && !first) ? ST_EMA : ST_EVAL;
        end
      end
      ST_EMA:  if (ema_done) state_d = ST_EVAL;
      ST_EVAL: state_d = (est_valid && rem_pages != '0) ? ST_MUL : ST_DONE;
      ST_MUL:  if (mcnt_q == MUL_LAST) state_d = ST_ADJ;
      ST_ADJ:  state_d = ST_DIV;
      ST_DIV:  if (min_done) state_d = ST_DONE;
      ST_DONE: if (!m_valid_q || m_axis_tready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    s_axis_tready = 1'b0;
    ema_start     = 1'b0;
    min_start     = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        ema_start     = accept && !cmd_reset && take && !first;
      end
      ST_ADJ:  min_start = 1'b1;
      ST_DONE: out_load  = !m_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  ptpe_cdiv #(
    .NUM_W  (EMA_NUM_W),
    .REM_W  (EMA_REM_W),
    .DIVISOR(EMA_DIV)
  ) u_ema_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(ema_start),
    .rem_i  ('0),
    .num_i  (ema_num),
    .done_o (ema_done),
    .quot_o (ema_quot)
  );

  ptpe_cdiv #(
    .NUM_W  (MIN_QUOT_W),
    .REM_W  (MIN_REM_W),
    .DIVISOR(MIN_DIV)
  ) u_min_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(min_start),
    .rem_i  ({1'b0, min_num[PROD_W-1:MIN_QUOT_W]}),
    .num_i  (min_num[MIN_QUOT_W-1:0]),
    .done_o (min_done),
    .quot_o (min_quot)
  );

  // Control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      page_total_q <= '0;
      page_pos_q   <= '0;
      last_q       <= '0;
      pace_q       <= '0;
      count_q      <= '0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        page_total_q <= cfg_wdata_i;
      end
      if (accept) begin
        if (cmd_reset) begin
          pace_q  <= '0;
          last_q  <= '0;
          count_q <= '0;
        end else begin
          page_pos_q <= next_page;
          if (jump) begin
            last_q <= '0;
          end else if (one_step) begin
            last_q <= now;
          end
          if (take) begin
            count_q <= count_inc;
            if (first) begin
              pace_q <= {elapsed[INTERVAL_W-1:0], {FRAC_W{1'b0}}};
            end
          end
        end
      end
      if (state_q == ST_EMA && ema_done) begin
        pace_q <= ema_quot[PACE_W-1:0];
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Multiply counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mcnt_q <= '0;
    end else if (state_q == ST_MUL) begin
      mcnt_q <= mcnt_q + 1'b1;
    end else begin
      mcnt_q <= '0;
    end
  end

  // Datapath registers: product, minutes, result payload
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_EVAL: begin
        valid_q <= est_valid;
        min_q   <= '0;
        prod_q  <= {{(PROD_W-PAGE_W){1'b0}}, rem_pages};
      end
      ST_MUL: prod_q <= {mul_sum, prod_q[PAGE_W-1:1]};
      ST_DIV: begin
        if (min_done) begin
          min_q <= (min_quot == '0) ? MINUTES_W'(1) : min_quot[MINUTES_W-1:0];
        end
      end
      default: ;
    endcase
    if (out_load) begin
      m_data_q <= {{(OUT_DATA_W-PAGE_W-PACE_W-COUNT_W-MINUTES_W){1'b0}},
                   min_q, count_q, pace_q, page_pos_q};
      m_user_q <= valid_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule
